@@ hdl/esw_pkg.sv @@
// ----------------------------------------------------------------------------
// esw_pkg
// Shared types and codes for the write-back shadow buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esw_pkg;

    // Default number of shadow bytes.
    localparam int ESW_DEPTH = 256;

    // Dirty bits are kept in rows of this many bits.
    localparam int ROW_BITS = 8;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Result kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] addr;
        logic [7:0] data;
        logic       bus_idle;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] addr_out;
        logic [7:0] data_out;
    } t_out_item;

    // Result of the shared priority encoder.
    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } t_prio_res;

endpackage

`default_nettype wire

@@ hdl/eeprom_shadow_writeback.sv @@
// ----------------------------------------------------------------------------
// eeprom_shadow_writeback
// Byte shadow RAM with a dirty bitmap in front of a slow nonvolatile store.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. A load only writes the shadow
// byte; a host write passes through the set state, and a host read through
// the read state up to its result. A write-back tick with the bus idle is
// accepted, then scanned group by group of 64 bytes until the first dirty
// group, then passes through the row and write-back states to the
// store-write command. The scan length is set by the shared 8-bit priority
// encoder, which looks at eight row flags per cycle. A result waits in an
// output register, and new transactions are accepted while it waits. There is
// no clearing pass after reset: each row of dirty bits has a flag that reset clears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eeprom_shadow_writeback
    import esw_pkg::*;
#(
    parameter int DEPTH = ESW_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    localparam int AW     = $clog2(DEPTH);
    localparam int GROUPS = (DEPTH + ROW_BITS - 1) / ROW_BITS;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CHUNKS = (GROUPS + 7) / 8;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int NZ_W   = CHUNKS * 8;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SET  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_ROW  = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;

    logic [2:0]        r_state,     n_state;
    logic [7:0]        r_addr,      n_addr;
    logic              r_in_range,  n_in_range;
    logic [CW-1:0]     r_chunk,     n_chunk;
    logic [GW-1:0]     r_group,     n_group;
    logic [AW-1:0]     r_wb_addr,   n_wb_addr;
    logic [GROUPS-1:0] r_nz,        n_nz;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,       n_out;

    logic          accept;
    logic          in_range_in;
    logic [AW-1:0] in_addr_aw;
    logic          out_free;
    logic          out_load;
    logic [NZ_W-1:0] nz_pad;
    logic [7:0]    chunk_bits;
    logic [7:0]    prio_in;
    t_prio_res     prio;

    logic          sh_wr_en;
    logic          sh_rd_en;
    logic [AW-1:0] sh_rd_addr;
    logic [7:0]    sh_q;
    logic          dt_wr_en;
    logic [7:0]    dt_wr_data;
    logic          dt_rd_en;
    logic [GW-1:0] dt_rd_addr;
    logic [7:0]    dt_q;
    logic [7:0]    dt_old;
    logic [7:0]    dt_cleared;
    logic [AW-1:0] row_addr;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign accept      = i_in_valid && !o_in_stall;
    assign in_range_in = (32'(i_in_item.addr) < 32'(DEPTH));
    assign in_addr_aw  = AW'(i_in_item.addr);
    assign out_free    = !r_out_valid || !i_out_stall;

    // Eight row flags per scan step; flags past the last row read as zero.
    assign nz_pad     = NZ_W'(r_nz);
    assign chunk_bits = nz_pad[r_chunk * 8 +: 8];
    assign prio_in    = (r_state == ST_ROW) ? dt_q : chunk_bits;

    esw_prio8 u_prio (
        .i_bits (prio_in),
        .o_res  (prio)
    );

    // A row whose flag is clear holds no dirty bit, whatever the RAM says.
    assign dt_old     = r_nz[r_group] ? dt_q : 8'd0;
    assign dt_cleared = dt_q & ~(8'd1 << prio.idx);
    assign row_addr   = AW'({r_group, prio.idx});

    assign sh_wr_en = accept && in_range_in &&
                      (i_in_item.req_type inside {REQ_WRITE, REQ_LOAD});
    assign sh_rd_en = (accept && in_range_in && i_in_item.req_type == REQ_READ) ||
                      (r_state == ST_ROW);
    assign sh_rd_addr = (r_state == ST_ROW) ? row_addr : in_addr_aw;

    assign dt_rd_en = (accept && in_range_in && i_in_item.req_type == REQ_WRITE) ||
                      (r_state == ST_SCAN && prio.found);
    assign dt_rd_addr = (r_state == ST_SCAN) ? GW'({r_chunk, prio.idx})
                                             : GW'(in_addr_aw >> 3);
    assign dt_wr_en   = (r_state == ST_SET) || (r_state == ST_ROW);
    assign dt_wr_data = (r_state == ST_SET) ? (dt_old | (8'd1 << r_addr[2:0])) : dt_cleared;

    esw_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_shadow (
        .i_clk     (i_clk),
        .i_wr_en   (sh_wr_en),
        .i_wr_addr (in_addr_aw),
        .i_wr_data (i_in_item.data),
        .i_rd_en   (sh_rd_en),
        .i_rd_addr (sh_rd_addr),
        .o_rd_data (sh_q)
    );

    esw_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (GROUPS)
    ) u_dirty (
        .i_clk     (i_clk),
        .i_wr_en   (dt_wr_en),
        .i_wr_addr (r_group),
        .i_wr_data (dt_wr_data),
        .i_rd_en   (dt_rd_en),
        .i_rd_addr (dt_rd_addr),
        .o_rd_data (dt_q)
    );

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_in_range  = r_in_range;
        n_chunk     = r_chunk;
        n_group     = r_group;
        n_wb_addr   = r_wb_addr;
        n_nz        = r_nz;
        n_out       = r_out;
        out_load    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_addr     = i_in_item.addr;
                    n_in_range = in_range_in;
                    n_group    = GW'(in_addr_aw >> 3);
                    n_chunk    = '0;
                    case (i_in_item.req_type)
                        REQ_WRITE: n_state = in_range_in ? ST_SET : ST_IDLE;
                        REQ_READ:  n_state = ST_RD;
                        REQ_TICK:  n_state = i_in_item.bus_idle ? ST_SCAN : ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SET: begin
                n_nz[r_group] = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_RD: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    n_out.kind     = KIND_READ;
                    n_out.addr_out = r_addr;
                    n_out.data_out = r_in_range ? sh_q : 8'd0;
                    n_state        = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (prio.found) begin
                    n_group = GW'({r_chunk, prio.idx});
                    n_state = ST_ROW;
                end else if (r_chunk == CW'(CHUNKS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            ST_ROW: begin
                n_nz[r_group] = |dt_cleared;
                n_wb_addr     = row_addr;
                n_state       = ST_WB;
            end
            ST_WB: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    n_out.kind     = KIND_STORE;
                    n_out.addr_out = 8'(r_wb_addr);
                    n_out.data_out = sh_q;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = out_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nz        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nz        <= n_nz;
            r_out_valid <= n_out_valid;
        end
        r_addr     <= n_addr;
        r_in_range <= n_in_range;
        r_chunk    <= n_chunk;
        r_group    <= n_group;
        r_wb_addr  <= n_wb_addr;
        r_out      <= n_out;
    end

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // A row picked by the group scan always holds a dirty bit.
    a_row_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW) |-> prio.found)
        else $error("selected dirty row is empty");

    // An in-range host write always goes on to mark its dirty bit.
    a_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_range_in && i_in_item.req_type == REQ_WRITE) |=> (r_state == ST_SET))
        else $error("host write did not update the dirty bitmap");

    // Results come only out of the read and write-back states.
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state == ST_RD || r_state == ST_WB))
        else $error("result produced from an unexpected state");

endmodule

`default_nettype wire

@@ hdl/esw_ram.sv @@
// ----------------------------------------------------------------------------
// esw_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esw_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // The read data holds until the next read is issued.
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/esw_prio8.sv @@
// ----------------------------------------------------------------------------
// esw_prio8
// Eight-bit lowest-set-bit encoder, shared by the group scan and the row scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esw_prio8
    import esw_pkg::*;
(
    input  wire logic [7:0] i_bits,
    output t_prio_res       o_res
);

    always_comb begin
        o_res.found = |i_bits;
        o_res.idx   = '0;
        // Walk from the top so that the lowest set bit wins.
        for (int i = 7; i >= 0; i--) begin
            if (i_bits[i]) begin
                o_res.idx = 3'(i);
            end
        end
    end

endmodule

`default_nettype wire
